@@ sv/gsp_pkg.sv @@
// shared types, constants and table functions for the gamepad serial poller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package gsp_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_TICK_W = 16;
  localparam int CFG_THR_W = 8;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes, byte address is four times the index
  localparam logic [2:0] REG_HALF_BIT = 3'd0;
  localparam logic [2:0] REG_BYTE_GAP = 3'd1;
  localparam logic [2:0] REG_ATT_GUARD = 3'd2;
  localparam logic [2:0] REG_HIGH_THR = 3'd3;
  localparam logic [2:0] REG_LOW_THR = 3'd4;

  localparam logic [CFG_TICK_W-1:0] HALF_BIT_RST = 16'd10;
  localparam logic [CFG_TICK_W-1:0] BYTE_GAP_RST = 16'd20;
  localparam logic [CFG_TICK_W-1:0] ATT_GUARD_RST = 16'd16;
  localparam logic [CFG_THR_W-1:0] HIGH_THR_RST = 8'd200;
  localparam logic [CFG_THR_W-1:0] LOW_THR_RST = 8'd50;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_POLL = 2'd1;
  localparam logic [1:0] CMD_SETUP = 2'd2;

  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_POLL = 8'h42;
  localparam logic [7:0] BYTE_CONFIG = 8'h43;
  localparam logic [7:0] BYTE_ANALOG = 8'h44;
  localparam logic [7:0] BYTE_LOCK = 8'h03;
  localparam logic [7:0] BYTE_FILL = 8'h5A;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE = 8'h01;

  localparam logic [7:0] MODE_ANALOG_RED = 8'h73;
  localparam logic [7:0] MODE_ANALOG_A = 8'h23;
  localparam logic [7:0] MODE_ANALOG_B = 8'h53;
  localparam logic [7:0] MODE_SHORT = 8'h12;

  localparam logic [2:0] SETUP_FRAMES = 3'd6;
  localparam logic [3:0] LEN_SHORT_FRAME = 4'd5;
  localparam logic [3:0] LEN_MID_FRAME = 4'd7;
  localparam logic [3:0] LEN_LONG_FRAME = 4'd9;

  localparam logic [1:0] FLAG_LOW = 2'd1;
  localparam logic [1:0] FLAG_HIGH = 2'd2;
  localparam logic [1:0] FLAG_NONE = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GUARD_IN,
    PH_BIT_HIGH,
    PH_BIT_LOW,
    PH_GAP,
    PH_GUARD_OUT,
    PH_FRAME_SEP
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       data_bit;
  } in_req_t;

  typedef struct packed {
    logic        attention_n;
    logic        clock_level;
    logic        command_bit;
    logic        frame_done;
    logic        busy_res;
    logic [7:0]  mode_id;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  direction_flags;
  } out_res_t;

  typedef struct packed {
    logic [CFG_TICK_W-1:0] half_bit_ticks;
    logic [CFG_TICK_W-1:0] byte_gap_ticks;
    logic [CFG_TICK_W-1:0] attention_guard_ticks;
    logic [CFG_THR_W-1:0]  high_threshold;
    logic [CFG_THR_W-1:0]  low_threshold;
  } cfg_t;

  // bytes sent in each of the six setup frames
  function automatic logic [7:0] setup_byte(input logic [2:0] frame, input logic [3:0] idx);
    logic [7:0] b;
    b = BYTE_ZERO;
    unique case (idx)
      4'd0: b = BYTE_START;
      4'd1: begin
        if (frame == 3'd3 || frame == 3'd5) begin
          b = BYTE_CONFIG;
        end else if (frame == 3'd4) begin
          b = BYTE_ANALOG;
        end else begin
          b = BYTE_POLL;
        end
      end
      4'd3: begin
        if (frame == 3'd3 || frame == 3'd4) begin
          b = BYTE_ONE;
        end
      end
      4'd4: begin
        if (frame == 3'd4) begin
          b = BYTE_LOCK;
        end else if (frame == 3'd5) begin
          b = BYTE_FILL;
        end
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        if (frame == 3'd5) begin
          b = BYTE_FILL;
        end
      end
      default: b = BYTE_ZERO;
    endcase
    if (frame >= SETUP_FRAMES) begin
      b = BYTE_ZERO;
    end
    return b;
  endfunction

  function automatic logic [7:0] tx_byte(input logic setup, input logic [2:0] frame,
                                         input logic [3:0] idx);
    logic [7:0] b;
    b = BYTE_ZERO;
    if (setup) begin
      b = setup_byte(frame, idx);
    end else if (idx == 4'd0) begin
      b = BYTE_START;
    end else if (idx == 4'd1) begin
      b = BYTE_POLL;
    end
    return b;
  endfunction

  function automatic logic [3:0] frame_len(input logic setup, input logic [2:0] frame,
                                           input logic [7:0] mode);
    logic [3:0] len;
    if (setup) begin
      if (frame >= SETUP_FRAMES) begin
        len = 4'd0;
      end else if (frame == 3'd4 || frame == 3'd5) begin
        len = LEN_LONG_FRAME;
      end else begin
        len = LEN_SHORT_FRAME;
      end
    end else if (mode == MODE_ANALOG_RED || mode == MODE_ANALOG_A || mode == MODE_ANALOG_B) begin
      len = LEN_LONG_FRAME;
    end else if (mode == MODE_SHORT) begin
      len = LEN_MID_FRAME;
    end else begin
      len = LEN_SHORT_FRAME;
    end
    return len;
  endfunction

  function automatic logic [1:0] axis_flags(input logic [7:0] v, input logic [7:0] hi,
                                            input logic [7:0] lo);
    logic [1:0] f;
    if (v > hi) begin
      f = FLAG_HIGH;
    end else if (v < lo) begin
      f = FLAG_LOW;
    end else begin
      f = FLAG_NONE;
    end
    return f;
  endfunction

endpackage

@@ sv/gsp_cfg_regs.sv @@
// configuration register bank behind an apb-style port
// depends on gsp_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module gsp_cfg_regs
  import gsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_bit_ticks <= HALF_BIT_RST;
      cfg_r.byte_gap_ticks <= BYTE_GAP_RST;
      cfg_r.attention_guard_ticks <= ATT_GUARD_RST;
      cfg_r.high_threshold <= HIGH_THR_RST;
      cfg_r.low_threshold <= LOW_THR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_HALF_BIT: cfg_r.half_bit_ticks <= pwdata[CFG_TICK_W-1:0];
        REG_BYTE_GAP: cfg_r.byte_gap_ticks <= pwdata[CFG_TICK_W-1:0];
        REG_ATT_GUARD: cfg_r.attention_guard_ticks <= pwdata[CFG_TICK_W-1:0];
        REG_HIGH_THR: cfg_r.high_threshold <= pwdata[CFG_THR_W-1:0];
        REG_LOW_THR: cfg_r.low_threshold <= pwdata[CFG_THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_HALF_BIT: prdata = CFG_DATA_W'(cfg_r.half_bit_ticks);
      REG_BYTE_GAP: prdata = CFG_DATA_W'(cfg_r.byte_gap_ticks);
      REG_ATT_GUARD: prdata = CFG_DATA_W'(cfg_r.attention_guard_ticks);
      REG_HIGH_THR: prdata = CFG_DATA_W'(cfg_r.high_threshold);
      REG_LOW_THR: prdata = CFG_DATA_W'(cfg_r.low_threshold);
      default: prdata = '0;
    endcase
  end

endmodule

@@ sv/gsp_core.sv @@
// wire sequencer: phase, timer, byte shifters and reply stores, one tick per step
// depends on gsp_pkg for phase_t, in_req_t, out_res_t, cfg_t and byte tables
`timescale 1ns / 1ps

module gsp_core
  import gsp_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_req_t  req,
  input  cfg_t     cfg,
  output out_res_t res
);

  localparam int CMP_W = (TIMER_BITS > CFG_TICK_W) ? TIMER_BITS : CFG_TICK_W;

  phase_t                phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt, t_inc;
  logic [2:0]            bit_cnt_r, bit_cnt_nxt;
  logic [3:0]            byte_r, byte_nxt;
  logic [2:0]            frame_r, frame_nxt;
  logic [7:0]            tx_r, tx_nxt;
  logic [7:0]            rx_r, rx_nxt;
  logic [7:0]            mode_r, mode_nxt;
  logic [15:0]           btn_r, btn_nxt;
  logic [7:0]            axis_r [4];
  logic [7:0]            axis_nxt [4];
  logic                  setup_r, setup_nxt;

  logic [CFG_TICK_W-1:0] half;
  logic                  el_half, el_gap, el_guard, t_max;
  logic                  do_after, do_next, do_close, do_start, do_enter, done;
  logic [3:0]            enter_idx, bi;
  logic [2:0]            fi;

  assign half = (cfg.half_bit_ticks == '0) ? CFG_TICK_W'(1) : cfg.half_bit_ticks;
  assign t_max = (timer_r == '1);
  assign t_inc = t_max ? timer_r : timer_r + TIMER_BITS'(1);
  assign el_half = (CMP_W'(t_inc) >= CMP_W'(half)) || (t_inc == '1);
  assign el_gap = (CMP_W'(t_inc) >= CMP_W'(cfg.byte_gap_ticks)) || (t_inc == '1);
  assign el_guard = (CMP_W'(t_inc) >= CMP_W'(cfg.attention_guard_ticks)) || (t_inc == '1);

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    bit_cnt_nxt = bit_cnt_r;
    byte_nxt = byte_r;
    frame_nxt = frame_r;
    tx_nxt = tx_r;
    rx_nxt = rx_r;
    mode_nxt = mode_r;
    btn_nxt = btn_r;
    axis_nxt = axis_r;
    setup_nxt = setup_r;
    do_after = 1'b0;
    do_next = 1'b0;
    do_close = 1'b0;
    do_start = 1'b0;
    do_enter = 1'b0;
    done = 1'b0;
    enter_idx = byte_r;
    bi = byte_r + 4'd1;
    fi = frame_r + 3'd1;

    unique case (phase_r)
      PH_IDLE: begin
        if (req.cmd == CMD_POLL || req.cmd == CMD_SETUP) begin
          setup_nxt = (req.cmd == CMD_SETUP);
          frame_nxt = '0;
          do_start = 1'b1;
        end
      end
      PH_GUARD_IN: begin
        timer_nxt = t_inc;
        if (el_guard) begin
          do_enter = 1'b1;
        end
      end
      PH_BIT_HIGH: begin
        timer_nxt = t_inc;
        if (el_half) begin
          phase_nxt = PH_BIT_LOW;
          timer_nxt = '0;
        end
      end
      PH_BIT_LOW: begin
        timer_nxt = t_inc;
        if (el_half) begin
          rx_nxt = {req.data_bit, rx_r[7:1]};
          tx_nxt = {1'b0, tx_r[7:1]};
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            do_after = 1'b1;
          end else begin
            phase_nxt = PH_BIT_HIGH;
            timer_nxt = '0;
          end
        end
      end
      PH_GAP: begin
        timer_nxt = t_inc;
        if (el_gap) begin
          do_next = 1'b1;
        end
      end
      PH_GUARD_OUT: begin
        timer_nxt = t_inc;
        if (el_guard) begin
          do_close = 1'b1;
        end
      end
      PH_FRAME_SEP: begin
        do_start = 1'b1;
      end
      default: begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
      end
    endcase

    // byte finished: keep poll replies
    if (do_after) begin
      if (!setup_r) begin
        unique case (byte_r)
          4'd1: mode_nxt = rx_nxt;
          4'd3: btn_nxt[7:0] = rx_nxt;
          4'd4: btn_nxt[15:8] = rx_nxt;
          4'd5: axis_nxt[0] = rx_nxt;
          4'd6: axis_nxt[1] = rx_nxt;
          4'd7: axis_nxt[2] = rx_nxt;
          4'd8: axis_nxt[3] = rx_nxt;
          default: ;
        endcase
      end
      if (cfg.byte_gap_ticks != '0) begin
        phase_nxt = PH_GAP;
        timer_nxt = '0;
      end else begin
        do_next = 1'b1;
      end
    end

    if (do_next) begin
      byte_nxt = bi;
      if (bi < frame_len(setup_r, frame_r, mode_nxt)) begin
        do_enter = 1'b1;
        enter_idx = bi;
      end else if (!setup_r) begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
        done = 1'b1;
      end else if (cfg.attention_guard_ticks != '0) begin
        phase_nxt = PH_GUARD_OUT;
        timer_nxt = '0;
      end else begin
        do_close = 1'b1;
      end
    end

    if (do_close) begin
      frame_nxt = fi;
      phase_nxt = (fi >= SETUP_FRAMES) ? PH_IDLE : PH_FRAME_SEP;
      timer_nxt = '0;
      done = (fi >= SETUP_FRAMES);
    end

    if (do_start) begin
      byte_nxt = '0;
      if (setup_nxt && cfg.attention_guard_ticks != '0) begin
        phase_nxt = PH_GUARD_IN;
        timer_nxt = '0;
      end else begin
        do_enter = 1'b1;
        enter_idx = '0;
      end
    end

    if (do_enter) begin
      tx_nxt = tx_byte(setup_nxt, frame_nxt, enter_idx);
      bit_cnt_nxt = '0;
      phase_nxt = PH_BIT_HIGH;
      timer_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      bit_cnt_r <= '0;
      byte_r <= '0;
      frame_r <= '0;
      tx_r <= '0;
      rx_r <= '0;
      mode_r <= '0;
      btn_r <= '0;
      axis_r[0] <= '0;
      axis_r[1] <= '0;
      axis_r[2] <= '0;
      axis_r[3] <= '0;
      setup_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      byte_r <= byte_nxt;
      frame_r <= frame_nxt;
      tx_r <= tx_nxt;
      rx_r <= rx_nxt;
      mode_r <= mode_nxt;
      btn_r <= btn_nxt;
      axis_r <= axis_nxt;
      setup_r <= setup_nxt;
    end
  end

  // line levels and stores as they stand after this tick
  always_comb begin
    res.attention_n = (phase_nxt == PH_IDLE) || (phase_nxt == PH_FRAME_SEP);
    res.clock_level = (phase_nxt != PH_BIT_LOW);
    res.command_bit = (phase_nxt == PH_BIT_HIGH || phase_nxt == PH_BIT_LOW) ? tx_nxt[0] : 1'b1;
    res.frame_done = done;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.mode_id = mode_nxt;
    res.buttons = btn_nxt;
    res.right_x = axis_nxt[0];
    res.right_y = axis_nxt[1];
    res.left_x = axis_nxt[2];
    res.left_y = axis_nxt[3];
    res.direction_flags = {
      axis_flags(axis_nxt[0], cfg.high_threshold, cfg.low_threshold),
      axis_flags(axis_nxt[1], cfg.high_threshold, cfg.low_threshold),
      axis_flags(axis_nxt[2], cfg.high_threshold, cfg.low_threshold),
      axis_flags(axis_nxt[3], cfg.high_threshold, cfg.low_threshold)
    };
  end

endmodule

@@ sv/gamepad_serial_poller_unit.sv @@
// top level of the gamepad serial poller: input register, sequencer core, result register
// depends on gsp_pkg, gsp_cfg_regs and gsp_core
`timescale 1ns / 1ps

// Usage:
// Each request on the in_ channel is one time tick: a command (none, poll,
// analog setup) and the sampled controller data line. Every request yields
// exactly one result on the out_ channel with the attention, clock and command
// line levels after that tick, the done and busy flags, the stored mode id,
// buttons, four axis bytes and the eight active-low direction flags.
// A request taken into the input register is stepped through the sequencer
// into the result register once that register is free, and is offered on
// out_valid from then on.
// Throughput is one request per cycle while out_stall is low; the sequencer state
// and result register update in the same cycle, so the sequencer step is the rate limit.
// When out_stall holds the result, one more request is still taken into the
// input register; further requests then see in_stall until the result leaves.
// The apb port holds the five timing and threshold registers at byte
// addresses 0, 4, 8, 12 and 16; write it only while no request is in flight.
// Reset (rst_n low, synchronous) empties both registers, returns the sequencer
// to idle with cleared stores and loads the register defaults.

module gamepad_serial_poller_unit
  import gsp_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_res_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  out_res_t res;
  in_req_t  req_r;
  out_res_t res_r;
  logic     req_valid_r;
  logic     res_valid_r;
  logic     advance;
  logic     in_take;

  assign advance = req_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign in_take = in_valid && !in_stall;
  assign out_valid = res_valid_r;
  assign out_data = res_r;

  gsp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsp_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .req   (req_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

endmodule
